FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the region prism checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PIR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PIR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pir_pkg.sv
// ----------------------------------------------------------------------------
// pir_pkg
// Types and constants shared by the region prism test block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pir_pkg;

  // Number of corner node cells in the chain.
  localparam int MAX_NODES = 16;

  typedef enum logic [1:0] {
    OP_QUERY       = 2'd0,
    OP_LOAD_NODE   = 2'd1,
    OP_LOAD_FLOOR  = 2'd2,
    OP_LOAD_BOUNDS = 2'd3
  } op_t;

  typedef enum logic {
    REG_NODE_COUNT    = 1'b0,
    REG_REGION_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t                operation;
    logic        [3:0]  index;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
  } in_item_t;

  typedef struct packed {
    logic               inside_res;
    logic signed [31:0] floor_height;
  } out_item_t;

  // A Q16.16 point or vector.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pt_t;

  // Query point travelling down the chain, one cell per cycle.
  typedef struct packed {
    logic tok;
    pt_t  pt;
  } fwd_t;

  // Running inside flag, trailing the point down the chain.
  typedef struct packed {
    logic tok;
    logic flag;
  } link_t;

  // Floor and top plane results of one query.
  typedef struct packed {
    logic               below;
    logic               above;
    logic signed [31:0] height;
  } floor_res_t;

endpackage

FILE: rtl/core/pir_cell.sv
// ----------------------------------------------------------------------------
// pir_cell
// One corner node of the region: holds its position and edge normal and tests
// the passing query point against its edge plane.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pir_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          active,
  input  logic          load_en,
  input  pir_pkg::pt_t  load_pos,
  input  pir_pkg::pt_t  load_nrm,
  input  pir_pkg::fwd_t fwd_in,
  output pir_pkg::fwd_t fwd_out,
  input  pir_pkg::link_t link_in,
  output pir_pkg::link_t link_out
);
  import pir_pkg::*;

  pt_t pos;
  pt_t nrm;

  logic signed [32:0] dx, dy, dz;
  logic signed [64:0] px, py, pz;
  logic               tok_b;
  logic signed [65:0] dot;

  always_ff @(posedge clk) begin
    if (load_en) begin
      pos <= load_pos;
      nrm <= load_nrm;
    end
  end

  assign dot = 66'(px) + 66'(py) + 66'(pz);

  // Difference, then products, then sign of the sum. Only the tokens are
  // cleared by reset; the data path carries none.
  always_ff @(posedge clk) begin
    fwd_out.pt    <= fwd_in.pt;
    dx            <= 33'(fwd_in.pt.x) - 33'(pos.x);
    dy            <= 33'(fwd_in.pt.y) - 33'(pos.y);
    dz            <= 33'(fwd_in.pt.z) - 33'(pos.z);
    px            <= dx * nrm.x;
    py            <= dy * nrm.y;
    pz            <= dz * nrm.z;
    link_out.flag <= link_in.flag & (~active | ~dot[65]);
    if (rst) begin
      fwd_out.tok  <= 1'b0;
      tok_b        <= 1'b0;
      link_out.tok <= 1'b0;
    end else begin
      fwd_out.tok  <= fwd_in.tok;
      tok_b        <= fwd_out.tok;
      link_out.tok <= tok_b & link_in.tok;
    end
  end

endmodule

FILE: rtl/core/pir_floor.sv
// ----------------------------------------------------------------------------
// pir_floor
// Floor plane distance through node zero, top plane test and saturated height.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pir_floor (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pir_pkg::pt_t        pt,
  input  pir_pkg::pt_t        p0,
  input  pir_pkg::pt_t        fn,
  input  logic [30:0]         region_height,
  output pir_pkg::floor_res_t res
);
  import pir_pkg::*;

  logic               tok1, tok2, tok3;
  logic signed [32:0] dx, dy, dz;
  logic signed [64:0] px, py, pz;
  logic signed [63:0] hp, hp2;
  logic signed [65:0] fdot;
  logic signed [66:0] tdot;
  logic signed [31:0] height;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok1 <= 1'b0;
      tok2 <= 1'b0;
      tok3 <= 1'b0;
    end else begin
      tok1 <= start;
      tok2 <= tok1;
      tok3 <= tok2;
    end
  end

  assign tdot = 67'(fdot) - 67'(hp2);

  // Shift right by 16 with floor rounding, then clamp to the int32 range.
  always_comb begin
    if (fdot[65:47] == '0 || fdot[65:47] == '1) begin
      height = fdot[47:16];
    end else if (fdot[65]) begin
      height = 32'sh8000_0000;
    end else begin
      height = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dx <= 33'(pt.x) - 33'(p0.x);
      dy <= 33'(pt.y) - 33'(p0.y);
      dz <= 33'(pt.z) - 33'(p0.z);
    end
    if (tok1) begin
      px <= dx * fn.x;
      py <= dy * fn.y;
      pz <= dz * fn.z;
      hp <= $signed({1'b0, region_height}) * fn.z;
    end
    if (tok2) begin
      fdot <= 66'(px) + 66'(py) + 66'(pz);
      hp2  <= hp;
    end
    if (tok3) begin
      res.below  <= fdot[65];
      res.above  <= ~tdot[66] & (tdot != '0);
      res.height <= height;
    end
  end

endmodule

FILE: rtl/core/point_in_region_prism.sv
// ----------------------------------------------------------------------------
// point_in_region_prism
// A query result is offered once the query has passed the node cell chain,
//   the holding stage and the output register; loads give no result.
// Only one query is in flight at a time, its point walking the node cell
//   chain one cell a cycle; loads may follow each other directly.
// Reset: control state clears at once; the box is inverted, the floor normal
//   is zero, node_count is 3 and region_height is 0; node slots hold nothing
//   until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_region_prism (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  pir_pkg::in_item_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output pir_pkg::out_item_t  result,
  input  logic                cfg_write,
  input  pir_pkg::cfg_reg_t   cfg_index,
  input  logic [30:0]         cfg_data
);
  import pir_pkg::*;

  // Configuration registers.
  logic [4:0]  node_count;
  logic [30:0] region_height;

  // Region state held outside the cells. Node zero's position is kept here
  // as well, since the floor plane passes through it.
  pt_t floor_nrm;
  pt_t box_min;
  pt_t box_max;
  pt_t node0_pos;

  // Handshake and sequencing.
  logic      busy;
  logic      accept;
  logic      query_go;
  logic      box_tok;
  logic      box_ok;
  logic      box_hit;
  link_t     head_link;
  logic      res_pending;
  out_item_t res;
  logic      out_free;

  pt_t        item_a;
  pt_t        item_b;
  floor_res_t floor_res;

  fwd_t                 fwd  [MAX_NODES];
  link_t                link [MAX_NODES+1];
  logic [MAX_NODES-1:0] active;
  logic [MAX_NODES-1:0] node_we;

  // One query is in flight at a time; the input side is held off from its
  // transfer until its result has moved into the output register.
  assign item_stall = busy;
  assign accept     = item_valid & ~item_stall;
  assign query_go   = accept & (item.operation == OP_QUERY);
  assign out_free   = ~result_valid | ~result_stall;

  assign item_a = '{x: item.ax, y: item.ay, z: item.az};
  assign item_b = '{x: item.bx, y: item.by, z: item.bz};

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= 5'd3;
      region_height <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NODE_COUNT:    node_count    <= cfg_data[4:0];
        REG_REGION_HEIGHT: region_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Floor normal and bounding box loads. The box resets inverted so that no
  // point is inside until real bounds arrive.
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_nrm <= '0;
      box_min   <= {3{32'h7FFF_FFFF}};
      box_max   <= {3{32'h8000_0000}};
    end else if (accept) begin
      unique case (item.operation)
        OP_LOAD_FLOOR: floor_nrm <= item_a;
        OP_LOAD_BOUNDS: begin
          box_min <= item_a;
          box_max <= item_b;
        end
        OP_QUERY, OP_LOAD_NODE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (node_we[0]) begin
      node0_pos <= item_a;
    end
  end

  // Bounds test, inclusive on both sides. It is taken at the transfer into box_ok
  // and registered again into head_link so that it meets cell zero's edge result.
  assign box_hit = (item.ax >= box_min.x) && (item.ax <= box_max.x) &&
                   (item.ay >= box_min.y) && (item.ay <= box_max.y) &&
                   (item.az >= box_min.z) && (item.az <= box_max.z);

  always_ff @(posedge clk) begin
    box_ok         <= box_hit;
    head_link.flag <= box_ok;
    if (rst) begin
      box_tok       <= 1'b0;
      head_link.tok <= 1'b0;
    end else begin
      box_tok       <= query_go;
      head_link.tok <= box_tok;
    end
  end

  assign link[0] = head_link;
  assign fwd[0]  = '{tok: query_go, pt: item_a};

  // The chain of node cells. The query point enters cell zero at its transfer
  // and moves on one cell a cycle; each cell's edge verdict joins the running
  // flag after its product registers. Cells at or beyond node_count pass the
  // flag on untouched, which also clamps a count above the number of cells.
  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    assign active[i]  = 32'(node_count) > 32'(i);
    assign node_we[i] = accept && (item.operation == OP_LOAD_NODE) &&
                        (32'(item.index) == 32'(i));

    if (i == MAX_NODES - 1) begin : g_last
      pir_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .active   (active[i]),
        .load_en  (node_we[i]),
        .load_pos (item_a),
        .load_nrm (item_b),
        .fwd_in   (fwd[i]),
        .fwd_out  (),
        .link_in  (link[i]),
        .link_out (link[i+1])
      );
    end else begin : g_mid
      pir_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .active   (active[i]),
        .load_en  (node_we[i]),
        .load_pos (item_a),
        .load_nrm (item_b),
        .fwd_in   (fwd[i]),
        .fwd_out  (fwd[i+1]),
        .link_in  (link[i]),
        .link_out (link[i+1])
      );
    end
  end

  // Floor and top planes run beside the chain and finish well before it.
  pir_floor u_floor (
    .clk           (clk),
    .rst           (rst),
    .start         (query_go),
    .pt            (item_a),
    .p0            (node0_pos),
    .fn            (floor_nrm),
    .region_height (region_height),
    .res           (floor_res)
  );

  // Result holding stage and output register. The holding stage keeps the
  // finished result while the output register still waits on its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      res_pending  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (query_go) begin
        busy <= 1'b1;
      end
      if (link[MAX_NODES].tok) begin
        res_pending <= 1'b1;
      end else if (res_pending && out_free) begin
        res_pending <= 1'b0;
        busy        <= 1'b0;
      end
      if (res_pending && out_free) begin
        result_valid <= 1'b1;
      end else if (~result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link[MAX_NODES].tok) begin
      res.inside_res   <= link[MAX_NODES].flag & ~floor_res.below & ~floor_res.above;
      res.floor_height <= floor_res.height;
    end
    if (res_pending && out_free) begin
      result <= res;
    end
  end

endmodule

FILE: rtl/core/pir_checker.sv
// ----------------------------------------------------------------------------
// pir_checker
// Port-level checks on the region prism block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pir_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input pir_pkg::in_item_t  item,
  input logic               result_valid,
  input logic               result_stall,
  input pir_pkg::out_item_t result
);
  import pir_pkg::*;

  // A query transfer holds off the input side in the following cycle.
  `PIR_ASSERT_NXT(a_query_blocks, clk, rst, item_valid && !item_stall && item.operation == OP_QUERY, item_stall, "query transfer did not hold off the input")

  // A fresh result only appears after a query held off the input.
  `PIR_ASSERT_IMP(a_result_after_query, clk, rst, $rose(result_valid), $past(item_stall), "result appeared without a query in flight")

  // A stalled result stays offered and unchanged.
  `PIR_ASSERT_NXT(a_result_held, clk, rst, result_valid && result_stall, result_valid, "stalled result was withdrawn")
  `PIR_ASSERT_NXT(a_result_stable, clk, rst, result_valid && result_stall, $stable(result), "stalled result changed")

endmodule

bind point_in_region_prism pir_checker u_checker (.*);
